// ----- rtl/frx_pkg.sv -----
// shared types and constants for the serial frame receiver
`default_nettype none

package frx_pkg;

	localparam logic [7:0] HDR_BYTE      = 8'hFE;
	localparam logic [7:0] RSP_BIT       = 8'h80;
	localparam logic [7:0] MAX_LEN_RESET = 8'd128;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CMD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 1'd1;

	typedef enum logic [2:0] {
		PH_HEAD  = 3'd0,
		PH_CMD1  = 3'd1,
		PH_CMD2  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} frx_phase_t;

	typedef struct packed {
		logic [7:0] expected_cmd;
		logic [7:0] max_payload_len;
	} frx_cfg_t;

	typedef struct packed {
		logic       frame_done;
		logic       checksum_ok;
		logic       response_match;
		logic       length_error;
		logic [7:0] frame_cmd1;
		logic [7:0] frame_cmd2;
	} frx_result_t;

endpackage

`default_nettype wire

// ----- rtl/frame_receiver_xor_check.sv -----
// top level of the serial frame receiver with xor check
`default_nettype none

// Serial frame receiver. Takes one received byte per word on the rx channel
// and parses frames laid out as 0xFE, cmd1, cmd2, len, len payload bytes,
// check, where check is the xor of cmd1, cmd2, len and the payload. Every
// accepted byte yields exactly one result word carrying frame_done,
// checksum_ok, response_match (good check, cmd1 equal to expected_cmd with
// bit 7 set), length_error (len above max_payload_len, frame dropped) and
// the command bytes seen so far. Throughput is one byte per clock while the
// result channel is not stalled; the parser state update is combinational
// logic between the input register and the result register, and result
// valid rises as the processed byte enters it. The input stage keeps taking
// bytes while a result waits, until both registers are full. Configuration
// is a write-only port: index 0 is expected_cmd, index 1 is max_payload_len.
module frame_receiver_xor_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration writes
	input  wire logic                          cfg_we,
	input  wire logic [frx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	// received byte channel
	input  wire logic                          rx_valid,
	output logic                               rx_stall,
	input  wire logic [7:0]                    rx_byte,
	// result channel
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic                               frame_done,
	output logic                               checksum_ok,
	output logic                               response_match,
	output logic                               length_error,
	output logic [7:0]                         frame_cmd1,
	output logic [7:0]                         frame_cmd2
);
	import frx_pkg::*;

	frx_cfg_t    cfg;
	frx_result_t res_comb;
	frx_result_t res_s2;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	logic        advance;
	logic        fire;
	logic        accept;

	// result register can take a new word when empty or being drained
	assign advance  = !valid_s2 || !res_stall;
	// the byte in the input register is processed when it can move on
	assign fire     = valid_s1 && advance;
	assign rx_stall = valid_s1 && !advance;
	assign accept   = rx_valid && !rx_stall;

	frx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) byte_s1 <= rx_byte;
	end

	frx_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_s2 <= res_comb;
	end

	assign res_valid      = valid_s2;
	assign frame_done     = res_s2.frame_done;
	assign checksum_ok    = res_s2.checksum_ok;
	assign response_match = res_s2.response_match;
	assign length_error   = res_s2.length_error;
	assign frame_cmd1     = res_s2.frame_cmd1;
	assign frame_cmd2     = res_s2.frame_cmd2;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a held word");

	a_fire_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed word did not reach the result register");

	a_flag_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && response_match |-> checksum_ok && frame_done && !length_error)
		else $error("inconsistent result flags");

endmodule

`default_nettype wire

// ----- rtl/frx_cfg_regs.sv -----
// configuration registers of the frame receiver
`default_nettype none

module frx_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [frx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output frx_pkg::frx_cfg_t                  cfg
);
	import frx_pkg::*;

	logic [7:0] expected_cmd_q;
	logic [7:0] max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_cmd_q <= '0;
			max_len_q      <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPECTED_CMD: expected_cmd_q <= cfg_data;
				CFG_MAX_LEN:      max_len_q      <= cfg_data;
			endcase
		end
	end

	assign cfg.expected_cmd    = expected_cmd_q;
	assign cfg.max_payload_len = max_len_q;

endmodule

`default_nettype wire

// ----- rtl/frx_parser.sv -----
// frame parser: per-byte state update and result flags
`default_nettype none

module frx_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   rx_byte,
	input  wire frx_pkg::frx_cfg_t cfg,
	output frx_pkg::frx_result_t res
);
	import frx_pkg::*;

	frx_phase_t phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] count_q, count_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] cmd1_q, cmd1_d;
	logic [7:0] cmd2_q, cmd2_d;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			len_q   <= '0;
			count_q <= '0;
			xor_q   <= '0;
			cmd1_q  <= '0;
			cmd2_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			count_q <= count_d;
			xor_q   <= xor_d;
			cmd1_q  <= cmd1_d;
			cmd2_q  <= cmd2_d;
		end
	end

	always_comb begin
		phase_d            = phase_q;
		len_d              = len_q;
		count_d            = count_q;
		xor_d              = xor_q;
		cmd1_d             = cmd1_q;
		cmd2_d             = cmd2_q;
		res.frame_done     = 1'b0;
		res.checksum_ok    = 1'b0;
		res.response_match = 1'b0;
		res.length_error   = 1'b0;
		unique case (phase_q)
			PH_HEAD: begin
				if (rx_byte == HDR_BYTE) phase_d = PH_CMD1;
			end
			PH_CMD1: begin
				cmd1_d  = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = PH_CMD2;
			end
			PH_CMD2: begin
				cmd2_d  = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (rx_byte > cfg.max_payload_len) begin
					// oversize length, drop the frame
					res.length_error = 1'b1;
					phase_d = PH_HEAD;
					len_d   = '0;
					count_d = '0;
					xor_d   = '0;
				end else begin
					xor_d   = xor_q ^ rx_byte;
					len_d   = rx_byte;
					phase_d = (rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
				end
			end
			PH_DATA: begin
				xor_d   = xor_q ^ rx_byte;
				count_d = count_inc;
				if (count_inc == len_q) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				res.frame_done  = 1'b1;
				res.checksum_ok = (xor_q == rx_byte);
				res.response_match = (xor_q == rx_byte) &&
					(cmd1_q == (cfg.expected_cmd | RSP_BIT));
				phase_d = PH_HEAD;
				len_d   = '0;
				count_d = '0;
				xor_d   = '0;
			end
			default: begin
				phase_d = PH_HEAD;
				len_d   = '0;
				count_d = '0;
				xor_d   = '0;
			end
		endcase
		res.frame_cmd1 = cmd1_d;
		res.frame_cmd2 = cmd2_d;
	end

	a_lerr_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.length_error |=> phase_q == PH_HEAD && xor_q == 8'd0)
		else $error("frame state not cleared after length error");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.frame_done |=> phase_q == PH_HEAD && count_q == 8'd0)
		else $error("frame state not cleared after check byte");

	a_data_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_DATA |=> count_q == $past(count_q) + 8'd1)
		else $error("payload count did not advance on a data byte");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(cmd1_q) && $stable(xor_q))
		else $error("parser state moved without a word");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking testbench for the serial frame receiver with xor check
module tb;
	import frx_pkg::*;

	// sender and receiver idling patterns, switched per phase
	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	localparam int BUSY_PCT    = 71;      // idle or stall chance when one side idles
	localparam int BOTH_PCT    = 31;      // idle and stall chance when both sides idle
	localparam int LONG_HOLD   = 150;     // cycles the receiver holds off to fill the block
	localparam int SETTLE      = 6;       // extra wait after the last word before the next phase
	localparam int MAX_REPORTS = 10;
	localparam int TIMEOUT     = 3000000; // watchdog delay, far above the slowest correct run

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPECTED_CMD;
	logic [7:0]           cfg_data  = 8'h00;
	logic                 rx_valid  = 1'b0;
	logic                 rx_stall;
	logic [7:0]           rx_byte   = 8'h00;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic                 frame_done;
	logic                 checksum_ok;
	logic                 response_match;
	logic                 length_error;
	logic [7:0]           frame_cmd1;
	logic [7:0]           frame_cmd2;

	// run control, written by the stimulus process at the rising edge
	idle_mode_t idle_mode  = IDLE_NONE;
	int         hold_token = 0;

	// bytes waiting for the driver and result words waiting for the monitor
	logic [7:0]  pending_bytes[$];
	frx_result_t expected_words[$];
	int          queued_total = 0;

	// parser copy used to work out the expected words
	frx_phase_t ph         = PH_HEAD;
	logic [7:0] frame_len  = 8'h00;
	logic [7:0] data_count = 8'h00;
	logic [7:0] xor_acc    = 8'h00;
	logic [7:0] cmd1_q     = 8'h00;
	logic [7:0] cmd2_q     = 8'h00;
	logic [7:0] cfg_exp    = 8'h00;
	logic [7:0] cfg_max    = MAX_LEN_RESET;

	// run statistics
	int bytes_sent    = 0;
	int words_seen    = 0;
	int frames_closed = 0;
	int good_checks   = 0;
	int cmd_matches   = 0;
	int len_drops     = 0;
	int bad_words     = 0;

	frame_receiver_xor_check DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.frame_done     (frame_done),
		.checksum_ok    (checksum_ok),
		.response_match (response_match),
		.length_error   (length_error),
		.frame_cmd1     (frame_cmd1),
		.frame_cmd2     (frame_cmd2)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// frame state back to waiting for a header, command bytes are kept
	function automatic void drop_frame();
		ph         = PH_HEAD;
		frame_len  = 8'h00;
		data_count = 8'h00;
		xor_acc    = 8'h00;
	endfunction

	// advance the parser copy by one byte and return the word it produces
	function automatic frx_result_t parse_byte(input logic [7:0] b);
		frx_result_t r;
		r = '0;
		case (ph)
			PH_HEAD: begin
				if (b == HDR_BYTE)
					ph = PH_CMD1;
			end
			PH_CMD1: begin
				cmd1_q  = b;
				xor_acc = xor_acc ^ b;
				ph      = PH_CMD2;
			end
			PH_CMD2: begin
				cmd2_q  = b;
				xor_acc = xor_acc ^ b;
				ph      = PH_LEN;
			end
			PH_LEN: begin
				xor_acc   = xor_acc ^ b;
				frame_len = b;
				// too long: drop the frame and flag it
				if (b > cfg_max) begin
					r.length_error = 1'b1;
					drop_frame();
				end else if (b != 8'h00) begin
					ph = PH_DATA;
				end else begin
					// empty payload goes straight to the check byte
					ph = PH_CHECK;
				end
			end
			PH_DATA: begin
				xor_acc    = xor_acc ^ b;
				data_count = data_count + 8'd1;
				if (data_count == frame_len)
					ph = PH_CHECK;
			end
			PH_CHECK: begin
				r.frame_done = 1'b1;
				if (xor_acc == b) begin
					r.checksum_ok = 1'b1;
					// bit 7 of the awaited command is forced on
					if (cmd1_q == (cfg_exp | RSP_BIT))
						r.response_match = 1'b1;
				end
				drop_frame();
			end
			default: begin
				drop_frame();
			end
		endcase
		r.frame_cmd1 = cmd1_q;
		r.frame_cmd2 = cmd2_q;
		return r;
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(0, 99) < BUSY_PCT;
			IDLE_BOTH: return $urandom_range(0, 99) < BOTH_PCT;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(0, 99) < BUSY_PCT;
			IDLE_BOTH: return $urandom_range(0, 99) < BOTH_PCT;
			default:   return 1'b0;
		endcase
	endfunction

	// driver: offers queued bytes, predicts each word as its byte is accepted
	always @(posedge clk or negedge arst_n) begin : byte_driver
		logic       offer;
		logic [7:0] next_byte;
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte  <= 8'h00;
		end else begin
			offer     = rx_valid;
			next_byte = rx_byte;
			if (rx_valid && !rx_stall) begin
				expected_words.push_back(parse_byte(rx_byte));
				bytes_sent++;
				offer = 1'b0;
			end
			// a new byte is offered only when the channel is free, never dropped
			if (!offer && pending_bytes.size() != 0 && !sender_idles()) begin
				offer     = 1'b1;
				next_byte = pending_bytes.pop_front();
			end
			rx_valid <= offer;
			rx_byte  <= next_byte;
		end
	end

	// monitor: checks each accepted word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : word_monitor
		int          hold_seen;
		int          hold_left;
		frx_result_t want;
		logic        stall_next;
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					bad_words++;
					if (bad_words <= MAX_REPORTS)
						$display("unexpected word: done=%0b ok=%0b match=%0b %s",
							frame_done, checksum_ok, response_match,
							$sformatf("lerr=%0b cmd1=%02h cmd2=%02h",
								length_error, frame_cmd1, frame_cmd2));
				end else begin
					want = expected_words.pop_front();
					frames_closed += want.frame_done;
					good_checks   += want.checksum_ok;
					cmd_matches   += want.response_match;
					len_drops     += want.length_error;
					if (frame_done !== want.frame_done ||
						checksum_ok !== want.checksum_ok ||
						response_match !== want.response_match ||
						length_error !== want.length_error ||
						frame_cmd1 !== want.frame_cmd1 ||
						frame_cmd2 !== want.frame_cmd2) begin
						bad_words++;
						if (bad_words <= MAX_REPORTS) begin
							$display("word %0d mismatch, expected done=%0b ok=%0b %s",
								words_seen, want.frame_done, want.checksum_ok,
								$sformatf("match=%0b lerr=%0b cmd1=%02h cmd2=%02h",
									want.response_match, want.length_error,
									want.frame_cmd1, want.frame_cmd2));
							$display("  got done=%0b ok=%0b %s",
								frame_done, checksum_ok,
								$sformatf("match=%0b lerr=%0b cmd1=%02h cmd2=%02h",
									response_match, length_error,
									frame_cmd1, frame_cmd2));
						end
					end
				end
			end
			// a new hold request starts a long stall so the input side backs up
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = receiver_stalls();
			end
			res_stall <= stall_next;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		queued_total++;
	endtask

	// whole frame with random payload, check byte optionally corrupted
	task automatic send_frame(input logic [7:0] c1, input logic [7:0] c2,
		input logic [7:0] len, input bit corrupt);
		logic [7:0] x;
		logic [7:0] p;
		x = c1 ^ c2 ^ len;
		push_byte(HDR_BYTE);
		push_byte(c1);
		push_byte(c2);
		push_byte(len);
		for (int i = 0; i < len; i++) begin
			p = 8'($urandom);
			x = x ^ p;
			push_byte(p);
		end
		push_byte(corrupt ? x ^ 8'($urandom_range(1, 255)) : x);
	endtask

	// mostly well-formed frames, some too long, truncated or plain noise
	task automatic random_traffic(input int n);
		int         stop_at;
		int         kind;
		int         cap;
		logic [7:0] c1;
		stop_at = queued_total + n;
		while (queued_total < stop_at) begin
			kind = $urandom_range(0, 99);
			c1   = ($urandom_range(0, 1) != 0) ? (cfg_exp | RSP_BIT) : 8'($urandom);
			if (kind < 65 || (kind < 77 && cfg_max == 8'hFF)) begin
				// short payloads mostly, now and then up to 40
				cap = (cfg_max < 6) ? cfg_max : 6;
				if ($urandom_range(0, 9) == 0)
					cap = (cfg_max < 40) ? cfg_max : 40;
				send_frame(c1, 8'($urandom), 8'($urandom_range(0, cap)),
					$urandom_range(0, 4) == 0);
			end else if (kind < 77) begin
				push_byte(HDR_BYTE);
				push_byte(c1);
				push_byte(8'($urandom));
				push_byte(8'($urandom_range(int'(cfg_max) + 1, 255)));
			end else if (kind < 87) begin
				// header and a few bytes, the next frame lands mid-parse
				push_byte(HDR_BYTE);
				repeat ($urandom_range(0, 3))
					push_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 3))
					push_byte(8'($urandom));
			end
		end
	endtask

	// register writes happen only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_EXPECTED_CMD: cfg_exp = val;
			CFG_MAX_LEN:      cfg_max = val;
			default:          ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic start_phase(input idle_mode_t mode, input bit long_hold);
		@(posedge clk);
		idle_mode <= mode;
		if (long_hold)
			hold_token <= hold_token + 1;
		@(negedge clk);
	endtask

	// sender pauses here until every predicted word has come back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || rx_valid || expected_words.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] lim;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed words with reset settings: noise, empty payload with a
		// command match, bad check, length over the limit, header value as commands
		start_phase(IDLE_NONE, 1'b0);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hFD);
		send_frame(8'h80, 8'h55, 8'h00, 1'b0);
		send_frame(8'hFF, 8'h00, 8'h01, 1'b1);
		push_byte(HDR_BYTE);
		push_byte(8'h01);
		push_byte(8'h02);
		push_byte(MAX_LEN_RESET + 8'd1);
		send_frame(HDR_BYTE, HDR_BYTE, 8'h02, 1'b0);
		drain();

		// zero length limit, only empty payloads pass
		write_reg(CFG_EXPECTED_CMD, 8'h7F);
		write_reg(CFG_MAX_LEN, 8'h00);
		start_phase(IDLE_SEND, 1'b0);
		random_traffic(60);
		drain();

		// full length limit with one frame of the largest payload, receiver
		// holds off at the start so the input side stalls
		write_reg(CFG_EXPECTED_CMD, 8'hFF);
		write_reg(CFG_MAX_LEN, 8'hFF);
		start_phase(IDLE_RECV, 1'b1);
		send_frame(8'hFF, 8'($urandom), 8'hFF, 1'b0);
		random_traffic(60);
		drain();

		// random settings, frames right at and just over the limit
		lim = 8'($urandom_range(1, 30));
		write_reg(CFG_EXPECTED_CMD, 8'($urandom));
		write_reg(CFG_MAX_LEN, lim);
		start_phase(IDLE_BOTH, 1'b0);
		send_frame(cfg_exp | RSP_BIT, 8'($urandom), lim, 1'b0);
		push_byte(HDR_BYTE);
		push_byte(8'($urandom));
		push_byte(8'($urandom));
		push_byte(lim + 8'd1);
		random_traffic(80);
		drain();

		// back to reset values, no idling on either side
		write_reg(CFG_EXPECTED_CMD, 8'h00);
		write_reg(CFG_MAX_LEN, MAX_LEN_RESET);
		start_phase(IDLE_NONE, 1'b0);
		random_traffic(50);
		drain();

		$display("sent %0d bytes and checked %0d result words over five register settings",
			bytes_sent, words_seen);
		$display("%0d frames closed, %0d good checks, %0d command matches, %s",
			frames_closed, good_checks, cmd_matches,
			$sformatf("%0d length drops, %0d bad words", len_drops, bad_words));
		if (bad_words == 0 && expected_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT);
		$display("timeout with %0d words still expected", expected_words.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- frame_receiver_xor_check.f -----
rtl/frx_pkg.sv
rtl/frx_cfg_regs.sv
rtl/frx_parser.sv
rtl/frame_receiver_xor_check.sv
bench/tb.sv
